// File: hdl/point_light_shadow_score_assert.svh
// Assertion macros for the point light shadow score block.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef POINT_LIGHT_SHADOW_SCORE_ASSERT_SVH
`define POINT_LIGHT_SHADOW_SCORE_ASSERT_SVH

// Same-cycle implication, checks off during reset
`define PLSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checks off during reset
`define PLSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset
`define PLSS_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/plss_pkg.sv
// Package for the point light shadow score block: payload structs and constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package plss_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;
  localparam int SCORE_W       = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Z = 2'd2;

  typedef struct packed {
    logic               light_enabled;
    logic signed [31:0] light_x;
    logic signed [31:0] light_y;
    logic signed [31:0] light_z;
    logic signed [31:0] light_intensity;
    logic signed [31:0] light_range;
  } in_t;

  typedef struct packed {
    logic [SCORE_W-1:0] priority_score;
    logic               score_saturated;
  } out_t;

endpackage
`default_nettype wire

// File: hdl/point_light_shadow_score.sv
// Point light shadow score: fully pipelined, one transaction per cycle.
// Stages: 3 front stages, 32 stages of ratio division, 5 multiply and
// setup stages, 48 stages of score division, one output register.
// Throughput one light per cycle; the whole pipe holds while the output waits.
// Synchronous active-low reset clears valid bits and camera registers to zero.
// Depends on plss_pkg.
`timescale 1ns / 1ps
`default_nettype none
module point_light_shadow_score #(
  parameter int FRAC_BITS = plss_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [plss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [plss_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire plss_pkg::in_t                     in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output plss_pkg::out_t                         out_data
);

  localparam int SH   = 32 - FRAC_BITS;
  localparam int DW   = 62 + SH;
  localparam int RW   = DW + 1;
  localparam int NSTG = 89;
  localparam int D1   = 32;
  localparam int D2   = plss_pkg::SCORE_W;
  localparam logic [63:0] EPS = ((64'd1 << (2 * FRAC_BITS)) + 64'd5000) / 64'd10000;

  typedef struct packed {
    logic        rej;
    logic [61:0] rem;
    logic [61:0] r2;
    logic [31:0] q;
    logic [61:0] d2;
    logic [61:0] p;
  } dv1_t;

  typedef struct packed {
    logic          rej;
    logic          sat;
    logic [DW-1:0] rem;
    logic [DW-1:0] dv;
    logic [D2-1:0] nlo;
    logic [D2-1:0] q;
  } dv2_t;

  function automatic logic [31:0] absd(input logic signed [31:0] a,
                                       input logic signed [31:0] b);
    logic signed [32:0] e;
    logic        [32:0] m;
    e = 33'(a) - 33'(b);
    m = e[32] ? 33'(-e) : 33'(e);
    return m[31:0];
  endfunction

  logic adv;
  logic [NSTG-1:0] vld_r;
  logic signed [31:0] cam_x_r, cam_y_r, cam_z_r;

  assign adv       = !vld_r[NSTG-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= '0;
      cam_y_r <= '0;
      cam_z_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        plss_pkg::CFG_CAMERA_X: cam_x_r <= cfg_wdata;
        plss_pkg::CFG_CAMERA_Y: cam_y_r <= cfg_wdata;
        plss_pkg::CFG_CAMERA_Z: cam_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage 1: distances and early reject
  logic        s1_rej_r, s1_rej_nxt;
  logic [30:0] s1_dx_r, s1_dy_r, s1_dz_r, s1_rng_r, s1_int_r;
  logic [31:0] ax, ay, az;

  always_comb begin
    ax = absd(in_data.light_x, cam_x_r);
    ay = absd(in_data.light_y, cam_y_r);
    az = absd(in_data.light_z, cam_z_r);
    s1_rej_nxt = !in_data.light_enabled
              || in_data.light_range[31] || (in_data.light_range == '0)
              || in_data.light_intensity[31] || (in_data.light_intensity == '0)
              || (ax > 32'(in_data.light_range)) || (ay > 32'(in_data.light_range))
              || (az > 32'(in_data.light_range));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_rej_r <= s1_rej_nxt;
      s1_dx_r  <= ax[30:0];
      s1_dy_r  <= ay[30:0];
      s1_dz_r  <= az[30:0];
      s1_rng_r <= in_data.light_range[30:0];
      s1_int_r <= in_data.light_intensity[30:0];
    end
  end

  // stage 2: squares and intensity * range
  logic        s2_rej_r;
  logic [61:0] s2_dx2_r, s2_dy2_r, s2_dz2_r, s2_r2_r, s2_p_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_rej_r <= s1_rej_r;
      s2_dx2_r <= 62'(s1_dx_r) * 62'(s1_dx_r);
      s2_dy2_r <= 62'(s1_dy_r) * 62'(s1_dy_r);
      s2_dz2_r <= 62'(s1_dz_r) * 62'(s1_dz_r);
      s2_r2_r  <= 62'(s1_rng_r) * 62'(s1_rng_r);
      s2_p_r   <= 62'(s1_int_r) * 62'(s1_rng_r);
    end
  end

  // stage 3: d^2 and range test
  dv1_t s3_r, s3_nxt;
  logic [63:0] d2_sum;

  always_comb begin
    d2_sum     = 64'(s2_dx2_r) + 64'(s2_dy2_r) + 64'(s2_dz2_r);
    s3_nxt.rej = s2_rej_r || (d2_sum >= 64'(s2_r2_r));
    s3_nxt.rem = d2_sum[61:0];
    s3_nxt.r2  = s2_r2_r;
    s3_nxt.q   = '0;
    s3_nxt.d2  = d2_sum[61:0];
    s3_nxt.p   = s2_p_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_r <= s3_nxt;
    end
  end

  // d^2 / r^2 to 32 fractional bits, one bit a stage
  dv1_t dv1_r [D1];
  dv1_t dv1_src [D1];

  for (genvar k = 0; k < D1; k++) begin : g_div1
    dv1_t        nxt;
    logic [62:0] shl;
    logic        ge;
    if (k == 0) begin : g_first
      assign dv1_src[k] = s3_r;
    end else begin : g_rest
      assign dv1_src[k] = dv1_r[k-1];
    end
    always_comb begin
      shl = {dv1_src[k].rem, 1'b0};
      ge  = shl >= {1'b0, dv1_src[k].r2};
      nxt = dv1_src[k];
      nxt.rem = ge ? 62'(shl - {1'b0, dv1_src[k].r2}) : shl[61:0];
      nxt.q   = {dv1_src[k].q[30:0], ge};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv1_r[k] <= nxt;
      end
    end
  end

  // t^2
  logic        st_rej_r;
  logic [31:0] st_t2_r;
  logic [61:0] st_d2_r, st_p_r;
  logic [63:0] t_prod;

  assign t_prod = 64'(dv1_r[D1-1].q) * 64'(dv1_r[D1-1].q);

  always_ff @(posedge clk) begin
    if (adv) begin
      st_rej_r <= dv1_r[D1-1].rej;
      st_t2_r  <= t_prod[63:32];
      st_d2_r  <= dv1_r[D1-1].d2;
      st_p_r   <= dv1_r[D1-1].p;
    end
  end

  // fade^2
  logic        sf_rej_r;
  logic [32:0] sf_f2_r, sf_f2_nxt;
  logic [61:0] sf_d2_r, sf_p_r;
  logic [31:0] fade;
  logic [63:0] f_prod;

  always_comb begin
    fade      = 32'(-st_t2_r);
    f_prod    = 64'(fade) * 64'(fade);
    sf_f2_nxt = (st_t2_r == '0) ? 33'h1_0000_0000 : {1'b0, f_prod[63:32]};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sf_rej_r <= st_rej_r;
      sf_f2_r  <= sf_f2_nxt;
      sf_d2_r  <= st_d2_r;
      sf_p_r   <= st_p_r;
    end
  end

  // partial products of p * fade^2
  logic        sn1_rej_r, sn1_fh_r;
  logic [62:0] sn1_pp0_r, sn1_pp1_r;
  logic [61:0] sn1_d2_r, sn1_p_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      sn1_rej_r <= sf_rej_r;
      sn1_fh_r  <= sf_f2_r[32];
      sn1_pp0_r <= 63'(sf_p_r[30:0]) * 63'(sf_f2_r[31:0]);
      sn1_pp1_r <= 63'(sf_p_r[61:31]) * 63'(sf_f2_r[31:0]);
      sn1_d2_r  <= sf_d2_r;
      sn1_p_r   <= sf_p_r;
    end
  end

  // numerator and scaled denominator
  logic          sn2_rej_r;
  logic [93:0]   sn2_n_r, num;
  logic [DW-1:0] sn2_dv_r;
  logic [61:0]   den;

  always_comb begin
    num = sn1_fh_r ? {sn1_p_r, 32'd0} : (94'(sn1_pp0_r) + (94'(sn1_pp1_r) << 31));
    den = (64'(sn1_d2_r) > EPS) ? sn1_d2_r : EPS[61:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sn2_rej_r <= sn1_rej_r;
      sn2_n_r   <= num;
      sn2_dv_r  <= {den, SH'(0)};
    end
  end

  // saturation test on the upper quotient bits
  dv2_t ss_r, ss_nxt;

  always_comb begin
    ss_nxt.rej = sn2_rej_r;
    ss_nxt.sat = RW'(sn2_n_r[93:D2]) >= RW'(sn2_dv_r);
    ss_nxt.rem = DW'(sn2_n_r[93:D2]);
    ss_nxt.dv  = sn2_dv_r;
    ss_nxt.nlo = sn2_n_r[D2-1:0];
    ss_nxt.q   = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ss_r <= ss_nxt;
    end
  end

  // score quotient, one bit a stage
  dv2_t dv2_r [D2];
  dv2_t dv2_src [D2];

  for (genvar j = 0; j < D2; j++) begin : g_div2
    dv2_t          nxt;
    logic [RW-1:0] shl;
    logic          ge;
    if (j == 0) begin : g_first
      assign dv2_src[j] = ss_r;
    end else begin : g_rest
      assign dv2_src[j] = dv2_r[j-1];
    end
    always_comb begin
      shl = {dv2_src[j].rem, dv2_src[j].nlo[D2-1]};
      ge  = shl >= {1'b0, dv2_src[j].dv};
      nxt = dv2_src[j];
      nxt.rem = ge ? DW'(shl - {1'b0, dv2_src[j].dv}) : shl[DW-1:0];
      nxt.nlo = {dv2_src[j].nlo[D2-2:0], 1'b0};
      nxt.q   = {dv2_src[j].q[D2-2:0], ge};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv2_r[j] <= nxt;
      end
    end
  end

  // output register
  plss_pkg::out_t out_r, out_nxt;

  always_comb begin
    if (dv2_r[D2-1].rej) begin
      out_nxt.priority_score  = '0;
      out_nxt.score_saturated = 1'b0;
    end else if (dv2_r[D2-1].sat) begin
      out_nxt.priority_score  = '1;
      out_nxt.score_saturated = 1'b1;
    end else begin
      out_nxt.priority_score  = dv2_r[D2-1].q;
      out_nxt.score_saturated = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

// File: hdl/plss_checker.sv
// Port checker for the point light shadow score block, bound to the top level.
// Depends on plss_pkg and point_light_shadow_score_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "point_light_shadow_score_assert.svh"
module plss_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire plss_pkg::out_t out_data
);

  `PLSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result transaction dropped")
  `PLSS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "result changed while stalled")
  `PLSS_ASSERT_NOW(a_sat_max, out_valid && out_data.score_saturated, out_data.priority_score == '1, "saturated score not at maximum")
  `PLSS_ASSERT_NEXT_ALWAYS(a_rst_empty, !rst_n, !out_valid && in_ready, "pipe not empty after reset")

endmodule

bind point_light_shadow_score plss_checker u_plss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

// File: dv/point_light_shadow_score_tb.sv
// Testbench for point_light_shadow_score: drives lights and camera settings, predicts each score.
// Runs directed and random lights, with random idling and stalls on both channels.
// Depends on plss_pkg and the point_light_shadow_score RTL.
`timescale 1ns / 1ps
module point_light_shadow_score_tb;

  localparam int          FB        = plss_pkg::FRAC_BITS_DEF;
  localparam logic [63:0] EPS_D2    = ((64'd1 << (2 * FB)) + 64'd5000) / 64'd10000;
  localparam logic [63:0] SCORE_TOP = (64'd1 << plss_pkg::SCORE_W) - 64'd1;
  localparam int          DRAIN_CYC = 120;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [plss_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [plss_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  plss_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  plss_pkg::out_t out_data;

  logic signed [31:0] cam_x = 0, cam_y = 0, cam_z = 0;
  plss_pkg::out_t score_q[$];
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int fails = 0;
  int n_scores = 0, n_nonzero = 0, n_sat = 0;

  point_light_shadow_score u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [63:0] abs_gap(logic signed [31:0] a, logic signed [31:0] b);
    longint sa, sb;
    sa = a;
    sb = b;
    return (sa >= sb) ? 64'(sa - sb) : 64'(sb - sa);
  endfunction

  function automatic plss_pkg::out_t predict_score(plss_pkg::in_t l);
    logic [63:0] dx, dy, dz, d2, r2, t, t2, fade, fade2, den, rng, inten;
    logic [127:0] num, q;
    plss_pkg::out_t r;
    r = '0;
    if (!l.light_enabled || l.light_range <= 0 || l.light_intensity <= 0) return r;
    rng = 64'(l.light_range);
    inten = 64'(l.light_intensity);
    dx = abs_gap(l.light_x, cam_x);
    dy = abs_gap(l.light_y, cam_y);
    dz = abs_gap(l.light_z, cam_z);
    if (dx > rng || dy > rng || dz > rng) return r;
    d2 = dx * dx + dy * dy + dz * dz;
    r2 = rng * rng;
    if (d2 >= r2) return r;
    num = {32'd0, d2, 32'd0};
    t = 64'(num / {64'd0, r2});
    t2 = (t * t) >> 32;
    fade = (64'd1 << 32) - t2;
    if (fade >= (64'd1 << 32)) fade2 = 64'd1 << 32;
    else fade2 = (fade * fade) >> 32;
    den = (d2 > EPS_D2) ? d2 : EPS_D2;
    num = {64'd0, inten * rng} * {64'd0, fade2};
    q = (num / {64'd0, den}) >> FB;
    if (q > {64'd0, SCORE_TOP}) begin
      r.priority_score = SCORE_TOP[plss_pkg::SCORE_W-1:0];
      r.score_saturated = 1'b1;
    end else begin
      r.priority_score = q[plss_pkg::SCORE_W-1:0];
    end
    return r;
  endfunction

  // result side: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 10);
    end
  end

  always @(posedge clk) begin
    plss_pkg::out_t exp_s;
    if (rst_n && out_valid && out_ready) begin
      if (score_q.size() == 0) begin
        $error("score transaction with no light pending");
        fails++;
      end else begin
        exp_s = score_q.pop_front();
        n_scores++;
        if (exp_s.priority_score != 0) n_nonzero++;
        if (exp_s.score_saturated) n_sat++;
        if (out_data.priority_score !== exp_s.priority_score) begin
          $error("priority_score exp %0d got %0d", exp_s.priority_score,
                 out_data.priority_score);
          fails++;
        end
        if (out_data.score_saturated !== exp_s.score_saturated) begin
          $error("score_saturated exp %0d got %0d", exp_s.score_saturated,
                 out_data.score_saturated);
          fails++;
        end
      end
    end
  end

  task automatic send_light(plss_pkg::in_t l);
    if (!calm && $urandom_range(0, 99) < 4) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= l;
    do @(posedge clk); while (!in_ready);
    score_q.push_back(predict_score(l));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (score_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic set_camera(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z);
    cfg_we <= 1'b1; cfg_index <= plss_pkg::CFG_CAMERA_X; cfg_wdata <= x;
    @(posedge clk);
    cfg_index <= plss_pkg::CFG_CAMERA_Y; cfg_wdata <= y;
    @(posedge clk);
    cfg_index <= plss_pkg::CFG_CAMERA_Z; cfg_wdata <= z;
    @(posedge clk);
    cfg_we <= 1'b0;
    cam_x = x; cam_y = y; cam_z = z;
  endtask

  function automatic plss_pkg::in_t mk_light(bit en, logic signed [31:0] x,
                                             logic signed [31:0] y,
                                             logic signed [31:0] z,
                                             logic signed [31:0] inten,
                                             logic signed [31:0] rng);
    plss_pkg::in_t l;
    l.light_enabled = en; l.light_x = x; l.light_y = y; l.light_z = z;
    l.light_intensity = inten; l.light_range = rng;
    return l;
  endfunction

  function automatic logic signed [31:0] near_offset(logic [31:0] rng);
    logic [31:0] m;
    m = $urandom_range(0, rng);
    if ($urandom_range(0, 2) == 0) m = m >> $urandom_range(1, 12);
    return $urandom_range(0, 1) ? -$signed(m) : $signed(m);
  endfunction

  function automatic plss_pkg::in_t rand_light();
    plss_pkg::in_t l;
    logic [31:0] rng;
    logic [191:0] raw;
    if ($urandom_range(0, 99) < 20) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      l = raw[$bits(plss_pkg::in_t)-1:0];
      return l;
    end
    rng = $urandom_range(1, 32'h7fffffff >> $urandom_range(0, 30));
    l.light_enabled = 1'b1;
    l.light_range = rng;
    l.light_intensity = $urandom_range(1, 32'h7fffffff >> $urandom_range(0, 30));
    l.light_x = cam_x + near_offset(rng);
    l.light_y = cam_y + near_offset(rng);
    l.light_z = cam_z + near_offset(rng);
    return l;
  endfunction

  task automatic test_rejects();
    send_light(mk_light(0, 0, 0, 32'h10000, 32'h10000, 32'h50000));
    send_light(mk_light(1, 0, 0, 32'h10000, 32'h10000, 0));
    send_light(mk_light(1, 0, 0, 32'h10000, 32'h10000, 32'h80000000));
    send_light(mk_light(1, 0, 0, 32'h10000, 0, 32'h50000));
    send_light(mk_light(1, 0, 0, 32'h10000, 32'h80000000, 32'h50000));
    send_light(mk_light(1, 32'h60000, 0, 0, 32'h10000, 32'h50000));
    send_light(mk_light(1, 32'h40000, 32'h40000, 0, 32'h10000, 32'h50000));
    send_light(mk_light(1, 32'h50000, 0, 0, 32'h10000, 32'h50000));
    send_light(mk_light(1, 0, 32'h30000, 32'h40000, 32'h10000, 32'h50000));
  endtask

  task automatic test_extremes();
    send_light(mk_light(1, 0, 0, 0, 32'h10000, 32'h10000));
    send_light(mk_light(1, 0, 0, 0, 32'h7fffffff, 32'h7fffffff));
    send_light(mk_light(1, 0, 0, 0, 1, 1));
    send_light(mk_light(1, 1, 0, 0, 32'h7fffffff, 32'h7fffffff));
    send_light(mk_light(1, 32'h100, 32'h100, 32'h100, 32'h7fffffff, 32'h7fffffff));
    send_light(mk_light(1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                        32'h7fffffff, 32'h7fffffff));
    send_light(mk_light(1, 32'h80000000, 0, 0, 32'h10000, 32'h7fffffff));
    send_light(mk_light(1, 32'h10000, 32'h8000, 32'h4000, 32'h20000, 32'h40000));
    send_light(mk_light(1, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 1, 32'h7fffffff));
    wait_idle();
  endtask

  task automatic test_camera_extremes();
    set_camera(32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_light(mk_light(1, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h10000, 32'h10000));
    send_light(mk_light(1, 32'h80000000, 32'h7fffffff, 32'h80000000,
                        32'h7fffffff, 32'h7fffffff));
    send_light(mk_light(1, 32'h7ffe0000, 32'h80020000, 32'h7fff0000,
                        32'h7fffffff, 32'h40000));
    repeat (40) send_light(rand_light());
    wait_idle();
    set_camera(32'h80000000, 32'h7fffffff, 32'h80000000);
    send_light(mk_light(1, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h10000, 1));
    repeat (40) send_light(rand_light());
    wait_idle();
  endtask

  task automatic test_random(int n);
    set_camera($urandom, $urandom, $urandom);
    repeat (n) send_light(rand_light());
    wait_idle();
  endtask

  task automatic test_backpressure();
    calm = 1'b1;
    hold_req = 1'b1;
    repeat (150) send_light(rand_light());
    calm = 1'b0;
    wait_idle();
  endtask

  task automatic test_pause();
    repeat (20) send_light(rand_light());
    in_valid <= 1'b0;
    while (score_q.size() != 0) @(posedge clk);
    repeat (20) send_light(rand_light());
    wait_idle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_rejects();
    test_extremes();
    test_camera_extremes();
    set_camera(32'h12340, -32'sh56780, 32'h9abc0);
    test_random(100);
    test_backpressure();
    test_pause();
    calm = 1'b1;
    test_random(60);
    calm = 1'b0;
    test_random(100);
    set_camera(0, 0, 0);
    test_random(40);
    $display("Scores checked: %0d, non-zero %0d, saturated %0d.", n_scores, n_nonzero, n_sat);
    $display("Covered rejects, range edges, camera extremes, stalls and pauses.");
    if (fails == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #10ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
